FILE: hw/rtl/dvrt_pkg.sv
package dvrt_pkg;

  localparam int unsigned NODES = 16;
  localparam int unsigned NW    = 4;           // node index width
  localparam int unsigned NCW   = NW + 1;      // node counter width, holds NODES
  localparam int unsigned DW    = 16;          // distance width
  localparam int unsigned HW    = 5;           // next hop width
  localparam int unsigned CW    = 2 * NW;      // cache address {row, col}

  localparam logic [HW-1:0] NO_HOP      = 5'd16;
  localparam logic [DW-1:0] UNREACH_RST = 16'd16;

  typedef enum logic [1:0] {
    REQ_LINK  = 2'd0,
    REQ_VEC   = 2'd1,
    REQ_ADV   = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  localparam logic [1:0] CFG_SELF    = 2'd0;
  localparam logic [1:0] CFG_MASK    = 2'd1;
  localparam logic [1:0] CFG_UNREACH = 2'd2;

  typedef struct packed {
    logic          known;
    logic [DW-1:0] distance;
    logic [HW-1:0] hop;
  } route_t;

  typedef struct packed {
    logic          en;
    logic [NW-1:0] addr;
    route_t        data;
  } route_wr_t;

  typedef struct packed {
    logic          changed;
    logic          found;
    logic [NW-1:0] node;
    logic [DW-1:0] distance;
    logic [HW-1:0] hop;
    logic          last;
  } res_t;

endpackage

FILE: hw/rtl/dvrt_route.sv
// Route table: known flag, distance, next hop per node. One read port.
module dvrt_route (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [dvrt_pkg::NW-1:0]          rd_addr_i,
  output dvrt_pkg::route_t                 rd_data_o,
  input  dvrt_pkg::route_wr_t              wr_i,
  input  logic [dvrt_pkg::NODES-1:0]       enter_i,
  input  logic [dvrt_pkg::DW-1:0]          unreach_i
);

  dvrt_pkg::route_t tab_q [dvrt_pkg::NODES];

  assign rd_data_o = tab_q[rd_addr_i];

  for (genvar i = 0; i < dvrt_pkg::NODES; i++) begin : g_ent
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tab_q[i] <= '{known: 1'b0, distance: dvrt_pkg::UNREACH_RST, hop: dvrt_pkg::NO_HOP};
      end else if (wr_i.en && (wr_i.addr == dvrt_pkg::NW'(i))) begin
        tab_q[i] <= wr_i.data;
      end else if (enter_i[i] && !tab_q[i].known) begin
        // node joins the neighbour set
        tab_q[i] <= '{known: 1'b1, distance: unreach_i, hop: dvrt_pkg::NO_HOP};
      end
    end
  end

endmodule

FILE: hw/rtl/dvrt_cache.sv
// Neighbour vector cache: present bits in flops, distances in a memory.
module dvrt_cache (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [dvrt_pkg::CW-1:0]          addr_i,
  output logic [dvrt_pkg::DW-1:0]          rd_data_o,
  output logic                             pres_o,
  input  logic                             wr_en_i,
  input  logic [dvrt_pkg::DW-1:0]          wr_data_i,
  input  logic                             set_i,
  input  logic [dvrt_pkg::NODES-1:0]       clr_rows_i,
  input  logic [dvrt_pkg::NW-1:0]          col_i,
  input  logic [dvrt_pkg::NODES-1:0]       col_mask_i,
  output logic                             col_any_o
);

  localparam int unsigned Depth = dvrt_pkg::NODES * dvrt_pkg::NODES;

  logic [Depth-1:0]          pres_q;
  logic [dvrt_pkg::DW-1:0]   mem [Depth];
  logic [dvrt_pkg::DW-1:0]   rd_q;
  logic [dvrt_pkg::NODES-1:0] col_hit;

  assign pres_o    = pres_q[addr_i];
  assign rd_data_o = rd_q;

  always_comb begin
    for (int r = 0; r < dvrt_pkg::NODES; r++) begin
      col_hit[r] = col_mask_i[r] && pres_q[{dvrt_pkg::NW'(r), col_i}];
    end
  end
  assign col_any_o = |col_hit;

  // row clear first, then the set of the written entry wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q <= '0;
    end else begin
      for (int k = 0; k < Depth; k++) begin
        if (set_i && (addr_i == dvrt_pkg::CW'(k))) begin
          pres_q[k] <= 1'b1;
        end else if (clr_rows_i[k / dvrt_pkg::NODES]) begin
          pres_q[k] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
    rd_q <= mem[addr_i];
  end

endmodule

FILE: hw/rtl/dvrt_relax.sv
// Shared relax unit: saturating add, then running minimum with low-index tie break.
module dvrt_relax (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       init_i,
  input  logic                       step_i,
  input  logic                       self_i,
  input  logic [dvrt_pkg::NW-1:0]    n_i,
  input  logic [dvrt_pkg::DW-1:0]    ld_i,
  input  logic [dvrt_pkg::DW-1:0]    cd_i,
  input  logic [dvrt_pkg::DW-1:0]    unreach_i,
  output logic [dvrt_pkg::DW-1:0]    best_o,
  output logic [dvrt_pkg::HW-1:0]    hop_o
);

  logic [dvrt_pkg::DW-1:0] best_q, best_d, d;
  logic [dvrt_pkg::HW-1:0] hop_q, hop_d, n_ext;
  logic [dvrt_pkg::DW:0]   sum;
  logic                    take;

  assign n_ext = {1'b0, n_i};
  assign sum   = {1'b0, ld_i} + {1'b0, cd_i};

  always_comb begin
    // ld_i is below infinity whenever step_i is high
    if (self_i) begin
      d = ld_i;
    end else if ((cd_i >= unreach_i) || (sum > {1'b0, unreach_i})) begin
      d = unreach_i;
    end else begin
      d = sum[dvrt_pkg::DW-1:0];
    end
    take   = step_i && ((d < best_q) || ((d == best_q) && (n_ext < hop_q)));
    best_d = best_q;
    hop_d  = hop_q;
    if (init_i) begin
      best_d = unreach_i;
      hop_d  = dvrt_pkg::NO_HOP;
    end else if (take) begin
      best_d = d;
      hop_d  = (d >= unreach_i) ? dvrt_pkg::NO_HOP : n_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= dvrt_pkg::UNREACH_RST;
      hop_q  <= dvrt_pkg::NO_HOP;
    end else begin
      best_q <= best_d;
      hop_q  <= hop_d;
    end
  end

  assign best_o = best_q;
  assign hop_o  = hop_q;

endmodule

FILE: hw/rtl/distance_vector_route_table_unit.sv
// Distance-vector route table with poison reverse for 16 nodes. Requests arrive one
// beat at a time on the slave stream and the block drops tready until the request is
// fully done. A link change or the last element of a vector runs a recompute: for
// every needed target (ascending, self skipped) one shared relax unit (saturating
// add and compare) walks all 16 nodes, one per cycle, through the single route-table
// read port and the registered cache read. Results leave through an output register,
// so the block keeps working while a result waits. Configuration writes are only
// legal while the block is idle.
module distance_vector_route_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // peer[3:0] target[7:4] metric[23:8] first[24]
                                       // has_entry[25], zero above
  input  logic [1:0]  s_axis_tuser_i,  // req_type
  input  logic        s_axis_tlast_i,  // last_in
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // changed[0] found[1] node[5:2] dist[21:6]
                                       // next_hop[26:22], zero above
  output logic        m_axis_tlast_o   // last_out
);

  localparam int unsigned NODES = dvrt_pkg::NODES;
  localparam int unsigned NW    = dvrt_pkg::NW;
  localparam int unsigned NCW   = dvrt_pkg::NCW;
  localparam int unsigned DW    = dvrt_pkg::DW;
  localparam int unsigned HW    = dvrt_pkg::HW;
  localparam int unsigned CW    = dvrt_pkg::CW;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_LINK   = 11'b000_0000_0010,
    S_VRD    = 11'b000_0000_0100,
    S_VWR    = 11'b000_0000_1000,
    S_TGT    = 11'b000_0001_0000,
    S_SCAN   = 11'b000_0010_0000,
    S_WB     = 11'b000_0100_0000,
    S_ADV    = 11'b000_1000_0000,
    S_ADVEND = 11'b001_0000_0000,
    S_QRY    = 11'b010_0000_0000,
    S_RES    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [NW-1:0]    self_q;
  logic [NODES-1:0] mask_q;
  logic [DW-1:0]    unreach_q;

  // request fields
  dvrt_pkg::req_e   req_type_q;
  logic [NW-1:0]    peer_q, target_q;
  logic [DW-1:0]    metric_q;
  logic             first_q, last_q, has_q;

  logic [NW-1:0]    t_q, t_d;
  logic [NCW-1:0]   n_q, n_d;
  logic             ch_q, ch_d;

  // scan pipeline stage
  logic             p_v_q, p_ok_q, p_self_q;
  logic [NW-1:0]    p_n_q;
  logic [DW-1:0]    p_ld_q;

  // pending advertisement entry
  logic             pend_v_q, pend_v_d;
  logic [NW-1:0]    pend_node_q, pend_node_d;
  logic [DW-1:0]    pend_dist_q, pend_dist_d;
  logic [HW-1:0]    pend_hop_q, pend_hop_d;

  // output register
  logic             o_valid_q;
  dvrt_pkg::res_t   o_res_q, push_res;
  logic             push_en, can_push;

  logic [NODES-1:0] nb_vec, self_oh, peer_oh, enter_vec;
  logic             in_acc;

  // route table / cache / relax hookup
  logic [NW-1:0]       rt_addr;
  dvrt_pkg::route_t    rt_rd;
  dvrt_pkg::route_wr_t rt_wr;
  logic [CW-1:0]       c_addr;
  logic [DW-1:0]       c_rd;
  logic                c_pres, c_wr_en, c_set, c_col_any;
  logic [NODES-1:0]    c_clr;
  logic                rx_init;
  logic [DW-1:0]       rx_best;
  logic [HW-1:0]       rx_hop;

  logic             peer_ok, nb_peer, t_last, need, elig, pres_eff, link_diff;
  logic             issue_ok;

  assign self_oh  = {{(NODES-1){1'b0}}, 1'b1} << self_q;
  assign peer_oh  = {{(NODES-1){1'b0}}, 1'b1} << peer_q;
  assign nb_vec   = mask_q & ~self_oh;
  assign peer_ok  = (peer_q != self_q);
  assign nb_peer  = nb_vec[peer_q];
  assign t_last   = (t_q == NW'(NODES - 1));
  assign can_push = !o_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // nodes that join the neighbour set on a mask write
  assign enter_vec = (cfg_we_i && (cfg_idx_i == dvrt_pkg::CFG_MASK)) ?
                     (cfg_wdata_i & ~mask_q & ~self_oh) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q    <= '0;
      mask_q    <= '0;
      unreach_q <= dvrt_pkg::UNREACH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dvrt_pkg::CFG_SELF:    self_q    <= cfg_wdata_i[NW-1:0];
        dvrt_pkg::CFG_MASK:    mask_q    <= cfg_wdata_i;
        dvrt_pkg::CFG_UNREACH: unreach_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dvrt_route u_route (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rt_addr),
    .rd_data_o (rt_rd),
    .wr_i      (rt_wr),
    .enter_i   (enter_vec),
    .unreach_i (unreach_q)
  );

  dvrt_cache u_cache (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .addr_i     (c_addr),
    .rd_data_o  (c_rd),
    .pres_o     (c_pres),
    .wr_en_i    (c_wr_en),
    .wr_data_i  (metric_q),
    .set_i      (c_set),
    .clr_rows_i (c_clr),
    .col_i      (t_q),
    .col_mask_i (nb_vec),
    .col_any_o  (c_col_any)
  );

  dvrt_relax u_relax (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .init_i    (rx_init),
    .step_i    (p_v_q && p_ok_q),
    .self_i    (p_self_q),
    .n_i       (p_n_q),
    .ld_i      (p_ld_q),
    .cd_i      (c_rd),
    .unreach_i (unreach_q),
    .best_o    (rx_best),
    .hop_o     (rx_hop)
  );

  // address muxing
  always_comb begin
    case (state_q)
      S_LINK:         rt_addr = peer_q;
      S_SCAN, S_ADV:  rt_addr = n_q[NW-1:0];
      S_QRY:          rt_addr = target_q;
      default:        rt_addr = t_q;
    endcase
    c_addr = (state_q == S_SCAN) ? {n_q[NW-1:0], t_q} : {peer_q, target_q};
  end

  assign need      = rt_rd.known || nb_vec[t_q] || c_col_any;
  assign elig      = rt_rd.known && (n_q[NW-1:0] != peer_q) && (n_q[NW-1:0] != self_q);
  assign pres_eff  = c_pres && !first_q;
  assign link_diff = (rt_rd.hop != {1'b0, peer_q}) || (rt_rd.distance != metric_q);
  assign issue_ok  = nb_vec[n_q[NW-1:0]] && rt_rd.known && (rt_rd.distance < unreach_q) &&
                     ((n_q[NW-1:0] == t_q) || c_pres);

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    n_d         = n_q;
    ch_d        = ch_q;
    pend_v_d    = pend_v_q;
    pend_node_d = pend_node_q;
    pend_dist_d = pend_dist_q;
    pend_hop_d  = pend_hop_q;
    rt_wr       = '0;
    c_wr_en     = 1'b0;
    c_set       = 1'b0;
    c_clr       = enter_vec;
    rx_init     = 1'b0;
    push_en     = 1'b0;
    push_res    = '{changed: ch_q, found: 1'b0, node: peer_q, distance: '0,
                    hop: dvrt_pkg::NO_HOP, last: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ch_d     = 1'b0;
          pend_v_d = 1'b0;
          n_d      = '0;
          case (dvrt_pkg::req_e'(s_axis_tuser_i))
            dvrt_pkg::REQ_LINK:  state_d = S_LINK;
            dvrt_pkg::REQ_VEC:   state_d = S_VRD;
            dvrt_pkg::REQ_ADV:   state_d = (s_axis_tdata_i[NW-1:0] != self_q) ? S_ADV : S_ADVEND;
            dvrt_pkg::REQ_QUERY: state_d = S_QRY;
            default:             state_d = S_IDLE;
          endcase
        end
      end

      S_LINK: begin
        if (peer_ok && rt_rd.known) begin
          if (link_diff) begin
            rt_wr.en   = 1'b1;
            rt_wr.addr = peer_q;
            rt_wr.data = '{known: 1'b1, distance: metric_q,
                           hop: (metric_q >= unreach_q) ? dvrt_pkg::NO_HOP : {1'b0, peer_q}};
            if ((metric_q >= unreach_q) && nb_peer) begin
              c_clr = peer_oh;
            end
            ch_d = 1'b1;
          end
          t_d     = '0;
          state_d = S_TGT;
        end else begin
          state_d = S_RES;
        end
      end

      S_VRD: state_d = S_VWR;

      S_VWR: begin
        if (nb_peer) begin
          if (first_q) begin
            c_clr = peer_oh;
          end
          if (has_q && (target_q != self_q)) begin
            c_set   = 1'b1;
            c_wr_en = !pres_eff || (metric_q < c_rd);
          end
        end
        t_d = '0;
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (nb_peer) begin
          state_d = S_TGT;
        end else begin
          state_d = S_RES;
        end
      end

      S_TGT: begin
        if ((t_q != self_q) && need) begin
          rx_init = 1'b1;
          n_d     = '0;
          state_d = S_SCAN;
        end else if (t_last) begin
          state_d = S_RES;
        end else begin
          t_d = t_q + NW'(1);
        end
      end

      S_SCAN: begin
        // last issue at NODES-1; the count of NODES drains the relax stage
        if (n_q == NCW'(NODES)) begin
          state_d = S_WB;
        end else begin
          n_d = n_q + NCW'(1);
        end
      end

      S_WB: begin
        if (!rt_rd.known || (rt_rd.hop != rx_hop) || (rt_rd.distance != rx_best)) begin
          ch_d = 1'b1;
        end
        rt_wr.en   = 1'b1;
        rt_wr.addr = t_q;
        rt_wr.data = '{known: 1'b1, distance: rx_best, hop: rx_hop};
        if (t_last) begin
          state_d = S_RES;
        end else begin
          t_d     = t_q + NW'(1);
          state_d = S_TGT;
        end
      end

      S_ADV: begin
        if (!(elig && pend_v_q && !can_push)) begin
          if (elig) begin
            if (pend_v_q) begin
              push_en  = 1'b1;
              push_res = '{changed: 1'b0, found: 1'b1, node: pend_node_q,
                           distance: pend_dist_q, hop: pend_hop_q, last: 1'b0};
            end
            pend_v_d    = 1'b1;
            pend_node_d = n_q[NW-1:0];
            pend_hop_d  = rt_rd.hop;
            pend_dist_d = (rt_rd.hop == {1'b0, peer_q}) ? unreach_q : rt_rd.distance;
          end
          if (n_q == NCW'(NODES - 1)) begin
            state_d = S_ADVEND;
          end else begin
            n_d = n_q + NCW'(1);
          end
        end
      end

      S_ADVEND: begin
        if (can_push) begin
          push_en = 1'b1;
          if (pend_v_q) begin
            push_res = '{changed: 1'b0, found: 1'b1, node: pend_node_q,
                         distance: pend_dist_q, hop: pend_hop_q, last: 1'b1};
          end else begin
            push_res = '{changed: 1'b0, found: 1'b0, node: peer_q, distance: '0,
                         hop: dvrt_pkg::NO_HOP, last: 1'b1};
          end
          state_d = S_IDLE;
        end
      end

      S_QRY: begin
        if (can_push) begin
          push_en = 1'b1;
          if (rt_rd.known) begin
            push_res = '{changed: 1'b0, found: 1'b1, node: target_q,
                         distance: rt_rd.distance, hop: rt_rd.hop, last: 1'b0};
          end else begin
            push_res = '{changed: 1'b0, found: 1'b0, node: target_q, distance: '0,
                         hop: dvrt_pkg::NO_HOP, last: 1'b0};
          end
          state_d = S_IDLE;
        end
      end

      S_RES: begin
        if (can_push) begin
          push_en = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      t_q       <= '0;
      n_q       <= '0;
      ch_q      <= 1'b0;
      pend_v_q  <= 1'b0;
      p_v_q     <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      t_q       <= t_d;
      n_q       <= n_d;
      ch_q      <= ch_d;
      pend_v_q  <= pend_v_d;
      p_v_q     <= (state_q == S_SCAN) && !n_q[NW];
      o_valid_q <= push_en || (o_valid_q && !m_axis_tready_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_type_q <= dvrt_pkg::req_e'(s_axis_tuser_i);
      peer_q     <= s_axis_tdata_i[3:0];
      target_q   <= s_axis_tdata_i[7:4];
      metric_q   <= s_axis_tdata_i[23:8];
      first_q    <= s_axis_tdata_i[24];
      has_q      <= s_axis_tdata_i[25];
      last_q     <= s_axis_tlast_i;
    end
    pend_node_q <= pend_node_d;
    pend_dist_q <= pend_dist_d;
    pend_hop_q  <= pend_hop_d;
    p_n_q       <= n_q[NW-1:0];
    p_ld_q      <= rt_rd.distance;
    p_ok_q      <= issue_ok;
    p_self_q    <= (n_q[NW-1:0] == t_q);
    if (push_en) begin
      o_res_q <= push_res;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tlast_o  = o_res_q.last;
  assign m_axis_tdata_o  = {5'd0, o_res_q.hop, o_res_q.distance, o_res_q.node,
                            o_res_q.found, o_res_q.changed};

  // request type only steers the dispatch; keep it visible for debug checks
  a_type_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VWR) |-> (req_type_q == dvrt_pkg::REQ_VEC))
    else $error("vector write without vector request");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |-> (!o_valid_q || m_axis_tready_i))
    else $error("result pushed over a waiting result");

  a_scan_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_v_q |-> $past(state_q == S_SCAN))
    else $error("relax step outside a scan");

  a_best_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WB) && (rx_hop != dvrt_pkg::NO_HOP)) |->
      (nb_vec[rx_hop[NW-1:0]] && (rx_best < unreach_q)))
    else $error("best route via a non-neighbour or at infinity");

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

endmodule
